[design/bes_pkg.sv]
package bes_pkg;

  // Default capacity of the element store.
  localparam int unsigned MAX_LEN_DEF = 32;

  // Width of one stored element (signed byte).
  localparam int unsigned DATA_W = 8;

  // Request from the sequencer to the output register.
  typedef struct packed {
    logic load;   // capture the memory read data as the next result
    logic last;   // that result closes the set
  } emit_t;

endpackage

[design/bes_ram.sv]
module bes_ram #(
  parameter int unsigned WIDTH = bes_pkg::DATA_W,
  parameter int unsigned DEPTH = bes_pkg::MAX_LEN_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value on cycles without a read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/bes_ctrl.sv]
module bes_ctrl #(
  parameter int unsigned MAX_LEN = bes_pkg::MAX_LEN_DEF,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int unsigned CW = $clog2(MAX_LEN + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [bes_pkg::DATA_W-1:0] in_value,
  input  logic                             in_last,
  input  logic                             out_free,
  output logic                             rd_en,
  output logic [AW-1:0]                    rd_addr,
  input  logic [bes_pkg::DATA_W-1:0]       rd_data,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [bes_pkg::DATA_W-1:0]       wr_data,
  output bes_pkg::emit_t                   emit
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_OUTER = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_INNER = 7'b0001000,
    S_WB    = 7'b0010000,
    S_ERD   = 7'b0100000,
    S_ELD   = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [CW-1:0]               j_r, j_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic [bes_pkg::DATA_W-1:0]  a_r, a_nxt;
  logic [CW-1:0]               ip1, jp1, kp1, n_last;
  logic                        room;

  assign ip1    = i_r + CW'(1);
  assign jp1    = j_r + CW'(1);
  assign kp1    = k_r + CW'(1);
  assign room   = (cnt_r < CW'(MAX_LEN));
  assign n_last = room ? (cnt_r + CW'(1)) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    a_nxt     = a_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    emit      = '0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (room) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[AW-1:0];
            wr_data = in_value;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_last) begin
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = (n_last > CW'(1)) ? S_OUTER : S_ERD;
          end
        end
      end
      S_OUTER: begin
        rd_en     = 1'b1;
        rd_addr   = i_r[AW-1:0];
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        // a_r takes the element at the outer position and keeps the smallest value seen in the pass.
        a_nxt     = rd_data;
        rd_en     = 1'b1;
        rd_addr   = ip1[AW-1:0];
        j_nxt     = ip1;
        state_nxt = S_INNER;
      end
      S_INNER: begin
        if ($signed(a_r) > $signed(rd_data)) begin
          wr_en   = 1'b1;
          wr_addr = j_r[AW-1:0];
          wr_data = a_r;
          a_nxt   = rd_data;
        end
        if (jp1 < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = jp1[AW-1:0];
          j_nxt   = jp1;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = i_r[AW-1:0];
        wr_data = a_r;
        i_nxt   = ip1;
        if ((ip1 + CW'(1)) < cnt_r) begin
          state_nxt = S_OUTER;
        end else begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r[AW-1:0];
        state_nxt = S_ELD;
      end
      S_ELD: begin
        if (out_free) begin
          emit.load = 1'b1;
          emit.last = (kp1 == cnt_r);
          k_nxt     = kp1;
          if (kp1 == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

endmodule

[design/byte_exchange_sorter_top.sv]
// Loading accepts requests back to back; a request without last gives no result.
// After the last request of n elements, the sort is paced by the single read
// port of the element memory (one compare per cycle).
// Each result is read from memory, then loaded once the output register is free.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid;
// the element memory is not cleared, since only entries of the current set are read.
module byte_exchange_sorter_top #(
  parameter int unsigned MAX_LEN = bes_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bes_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bes_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_end_of_set
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Memory ports driven by the sequencer.
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [bes_pkg::DATA_W-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [bes_pkg::DATA_W-1:0] wr_data;
  bes_pkg::emit_t             emit;

  // Output register state.
  logic                       out_valid_r;
  logic [bes_pkg::DATA_W-1:0] out_value_r;
  logic                       out_eos_r;
  logic                       out_free;

  // The output register can take a new result when it is empty or being drained
  // in this same cycle.
  assign out_free = !out_valid_r || out_ready;

  // The sequencer loads elements into the memory, runs the exchange sort as
  // read-compare-write passes, and streams the sorted set out of the memory.
  bes_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .in_last  (in_last),
    .out_free (out_free),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .emit     (emit)
  );

  // Element store: one write port and one registered read port.
  bes_ram #(
    .WIDTH (bes_pkg::DATA_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register decouples the result channel from the sequencer, so a new
  // set can start loading while the final result of the previous set still waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; it is only looked at while out_valid_r is set.
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_value_r <= rd_data;
      out_eos_r   <= emit.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_set   = out_eos_r;

endmodule

[design/bes_checker.sv]
module bes_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bes_pkg::DATA_W-1:0] out_sorted_value,
  input logic                              out_end_of_set
);

  logic                              out_acc;
  logic                              open_r;
  logic signed [bes_pkg::DATA_W-1:0] prev_r;

  assign out_acc = out_valid && out_ready;

  // Track the previous result of the set now being emitted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (out_acc) begin
      open_r <= !out_end_of_set;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_r <= out_sorted_value;
    end
  end

  // Results within one set come out in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && open_r |-> out_sorted_value >= prev_r)
    else $error("sorted results out of order");

  // A last request closes the set; no new request is taken in the next cycle.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request accepted right after the last one of a set");

  // No new set is loaded while a set is still being emitted. Once the final
  // result of the set sits in the output register, loading may resume.
  a_no_load_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    open_r && !(out_valid && out_end_of_set) |-> !in_ready)
    else $error("input ready while a set is still being emitted");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value)
      && $stable(out_end_of_set))
    else $error("stalled result changed");

endmodule

bind byte_exchange_sorter_top bes_checker u_bes_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sorted_value (out_sorted_value),
  .out_end_of_set   (out_end_of_set)
);

[tb/bes_checker.sv]
module bes_tb_checker #(
  parameter int unsigned MAX_LEN = bes_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [bes_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [bes_pkg::DATA_W-1:0] out_sorted_value,
  input  logic                              out_end_of_set,
  output int                                fail_count,
  output int                                pending_count,
  output int                                result_count
);

  typedef struct packed {
    logic [bes_pkg::DATA_W-1:0] sorted_value;
    logic                       end_of_set;
  } sorted_elem_t;

  // Elements of the set being loaded, in arrival order, then sorted in place.
  logic signed [bes_pkg::DATA_W-1:0] set_store [MAX_LEN];
  int                                set_len;
  sorted_elem_t                      sorted_queue [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
    set_len       = 0;
  end

  always @(posedge clk) begin
    sorted_elem_t                      want;
    logic signed [bes_pkg::DATA_W-1:0] swap_tmp;
    if (rst_n) begin
      // Results leave before the current request is folded in; any result
      // accepted now belongs to a set closed earlier.
      if (out_valid && out_ready) begin
        result_count++;
        if (sorted_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result %0d: value %0d end_of_set %0b",
                     result_count, out_sorted_value, out_end_of_set);
          end
        end else begin
          want = sorted_queue.pop_front();
          if (want.sorted_value !== out_sorted_value || want.end_of_set !== out_end_of_set) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d wrong: expected value %0d end_of_set %0b, got %0d %0b",
                       result_count, $signed(want.sorted_value), want.end_of_set,
                       out_sorted_value, out_end_of_set);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        // A full store drops the value but a last flag still closes the set.
        if (set_len < MAX_LEN) begin
          set_store[set_len] = in_value;
          set_len++;
        end
        if (in_last) begin
          for (int i = 0; i + 1 < set_len; i++) begin
            for (int j = i + 1; j < set_len; j++) begin
              if (set_store[i] > set_store[j]) begin
                swap_tmp     = set_store[i];
                set_store[i] = set_store[j];
                set_store[j] = swap_tmp;
              end
            end
          end
          for (int k = 0; k < set_len; k++) begin
            want.sorted_value = set_store[k];
            want.end_of_set   = (k + 1 == set_len);
            sorted_queue.push_back(want);
          end
          set_len = 0;
        end
      end

      pending_count = sorted_queue.size();
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top;

  // Capacity of the element store in the block under test.
  localparam int SET_CAP     = bes_pkg::MAX_LEN_DEF;
  // Number of random requests after the directed part.
  localparam int RANDOM_REQS = 140;
  // Past this many random requests neither side idles any more.
  localparam int QUIET_AFTER = 115;
  // Length of the one long receiver stall, in clock cycles.
  localparam int HOLD_CYCLES = 600;

  logic                              clk              = 1'b0;
  logic                              rst_n            = 1'b0;
  logic                              in_valid         = 1'b0;
  logic                              in_ready;
  logic signed [bes_pkg::DATA_W-1:0] in_value         = '0;
  logic                              in_last          = 1'b0;
  logic                              out_valid;
  logic                              out_ready        = 1'b0;
  logic signed [bes_pkg::DATA_W-1:0] out_sorted_value;
  logic                              out_end_of_set;

  int fail_count;
  int sorted_pending;
  int result_count;

  // Coordination between the request side and the result side.
  bit quiet     = 1'b0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  // Coverage tallies for the closing summary.
  int reqs_sent     = 0;
  int sets_sent     = 0;
  int overflow_sets = 0;

  byte_exchange_sorter_top #(
    .MAX_LEN(SET_CAP)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_value(out_sorted_value),
    .out_end_of_set  (out_end_of_set)
  );

  // The checker sees the same pins as the block and keeps its own sorted
  // copy of every closed set; it only reports counts back here.
  bes_tb_checker #(
    .MAX_LEN(SET_CAP)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_value(out_sorted_value),
    .out_end_of_set  (out_end_of_set),
    .fail_count      (fail_count),
    .pending_count   (sorted_pending),
    .result_count    (result_count)
  );

  // Free-running clock with a period of 12 time units.
  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog. A correct run finishes in a small fraction of this time, even
  // with every set at full size and every result stalled.
  initial begin
    #3000000;
    $display("byte_exchange_sorter_top: mismatch");
    $finish;
  end

  // Result side. Ready changes only at the falling edge. It idles in short
  // random bursts, and once, early in the random part, it holds off for a
  // long stretch so that a set waits in the block and the input backs up.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one request, entered and left at a falling edge. Before the
  // request the sender may idle for a random burst. Valid then stays high
  // with a steady payload until the rising edge at which ready is seen.
  task automatic offer_req(input int v, input logic l);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_value <= v[bes_pkg::DATA_W-1:0];
    in_last  <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    reqs_sent++;
    if (l) begin
      sets_sent++;
    end
  endtask

  // Request side: reset, directed sets, random sets, drain and verdict.
  initial begin
    int          rand_sent;
    int          set_idx;
    int          len;
    logic [31:0] r;

    rand_sent = 0;
    set_idx   = 0;

    // Synchronous reset, held from the start and released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-element sets at both ends of the signed range.
    offer_req(-128, 1'b1);
    offer_req(127, 1'b1);

    // Both extremes, zero and the values next to it, out of order.
    offer_req(127, 1'b0);
    offer_req(-128, 1'b0);
    offer_req(0, 1'b0);
    offer_req(-1, 1'b0);
    offer_req(1, 1'b1);

    // Repeated values must never be reordered into anything but their run.
    offer_req(5, 1'b0);
    offer_req(5, 1'b0);
    offer_req(5, 1'b0);
    offer_req(-3, 1'b0);
    offer_req(5, 1'b1);

    // Strictly descending input, the heaviest swapping case.
    offer_req(100, 1'b0);
    offer_req(50, 1'b0);
    offer_req(0, 1'b0);
    offer_req(-50, 1'b0);
    offer_req(-100, 1'b0);
    offer_req(-128, 1'b1);

    // Already ascending input, where nothing is swapped.
    offer_req(-128, 1'b0);
    offer_req(-1, 1'b0);
    offer_req(0, 1'b0);
    offer_req(127, 1'b1);

    // Random sets. The long receiver stall starts now, while the sender
    // keeps offering. Most sets are short; a few fill the store exactly
    // or run past it so that values, including a last one, are dropped.
    long_hold = 1'b1;
    while (rand_sent < RANDOM_REQS) begin
      if (set_idx == 2) begin
        len = SET_CAP;
      end else if (set_idx == 5) begin
        len = SET_CAP + 5;
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(20, SET_CAP + 8);
      end else begin
        len = $urandom_range(1, 8);
      end
      if (len > SET_CAP) begin
        overflow_sets++;
      end
      for (int k = 0; k < len; k++) begin
        r = $urandom;
        // A quarter of the values come from a narrow band around zero so that
        // equal values meet often.
        if (r[31:30] == 2'b00) begin
          r[7:0] = {{6{r[9]}}, r[1:0]};
        end
        offer_req(int'($signed(r[7:0])), k == len - 1);
        rand_sent++;
        if (rand_sent >= QUIET_AFTER) begin
          quiet = 1'b1;
        end
      end
      set_idx++;
    end
    in_valid <= 1'b0;

    // Wait for every predicted value, then a little longer for strays.
    while (sorted_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sorted %0d sets from %0d requests, %0d values checked in order.",
             sets_sent, reqs_sent, result_count);
    $display("%0d sets overran the %0d-entry store; one %0d-cycle output stall backed up input.",
             overflow_sets, SET_CAP, HOLD_CYCLES);
    if (fail_count == 0 && sorted_pending == 0) begin
      $display("byte_exchange_sorter_top: match");
    end else begin
      $display("byte_exchange_sorter_top: mismatch");
    end
    $finish;
  end

endmodule
